FILE: sv/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg: Roman numeral encoder shared definitions
// Widths, status codes, the numeral place table and the queue item type.
// ----------------------------------------------------------------------------
package rne_pkg;

    localparam int NUM_W    = 32;
    localparam int VAL_W    = 12;
    localparam int CHAR_W   = 8;
    localparam int PLACE_W  = 3;
    localparam int NUM_PLACES = 7;
    localparam int MAX_VALUE  = 3999;

    typedef logic [1:0]         t_status;
    typedef logic [VAL_W-1:0]   t_val;
    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [PLACE_W-1:0] t_place;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_POS   = 2'd1;
    localparam t_status ST_TOO_LARGE = 2'd2;

    localparam logic REG_PREFIX_MODE = 1'b0;
    localparam logic REG_LOWER_CASE  = 1'b1;

    localparam t_char LOWER_BIT = 8'h20;

    typedef struct packed {
        t_status status;
        t_val    value;
    } t_item;

    typedef struct packed {
        logic prefix_mode;
        logic lower_case;
    } t_cfg;

    // additive value of a place
    function automatic t_val add_value(input t_place p);
        t_val v;
        case (p)
            3'd0:    v = 12'd1000;
            3'd1:    v = 12'd500;
            3'd2:    v = 12'd100;
            3'd3:    v = 12'd50;
            3'd4:    v = 12'd10;
            3'd5:    v = 12'd5;
            default: v = 12'd1;
        endcase
        return v;
    endfunction

    function automatic t_char add_letter(input t_place p);
        t_char c;
        case (p)
            3'd0:    c = "M";
            3'd1:    c = "D";
            3'd2:    c = "C";
            3'd3:    c = "L";
            3'd4:    c = "X";
            3'd5:    c = "V";
            default: c = "I";
        endcase
        return c;
    endfunction

    // subtractive pair value; zero where the place has none
    function automatic t_val sub_value(input t_place p);
        t_val v;
        case (p)
            3'd0:    v = 12'd900;
            3'd1:    v = 12'd400;
            3'd2:    v = 12'd90;
            3'd3:    v = 12'd40;
            3'd4:    v = 12'd9;
            3'd5:    v = 12'd4;
            default: v = 12'd0;
        endcase
        return v;
    endfunction

    function automatic t_char sub_first(input t_place p);
        t_char c;
        case (p)
            3'd0, 3'd1: c = "C";
            3'd2, 3'd3: c = "X";
            default:    c = "I";
        endcase
        return c;
    endfunction

endpackage

FILE: sv/rne_num_if.sv
// ----------------------------------------------------------------------------
// rne_num_if: input number channel
// Valid/ready stream carrying one signed number per transfer.
// ----------------------------------------------------------------------------
interface rne_num_if;
    logic                               valid;
    logic                               ready;
    logic signed [rne_pkg::NUM_W-1:0]   number_in;

    modport source (output valid, output number_in, input ready);
    modport sink   (input valid, input number_in, output ready);
endinterface

FILE: sv/rne_chr_if.sv
// ----------------------------------------------------------------------------
// rne_chr_if: output character channel
// Valid/ready stream carrying one numeral letter, last marker and status.
// ----------------------------------------------------------------------------
interface rne_chr_if;
    logic                   valid;
    logic                   ready;
    rne_pkg::t_char         char_out;
    logic                   last_char;
    rne_pkg::t_status       status;

    modport source (output valid, output char_out, output last_char, output status,
                    input ready);
    modport sink   (input valid, input char_out, input last_char, input status,
                    output ready);
endinterface

FILE: sv/roman_numeral_encoder.sv
// The first letter of a number passes through the queue, the sequencer's item registers and then the output register.
// The sequencer sends one letter per cycle while the output is free to take it, and also
//   spends steps loading each item and skipping each place that gives no letter.
// A two-entry queue lets new numbers transfer in while letters are still going out.
// Reset (synchronous, active low) empties the queue and output; prefix_mode = 1,
//   lower_case = 0.
// ----------------------------------------------------------------------------
// roman_numeral_encoder: integer to Roman numeral
// Converts each signed number into a run of ASCII numeral letters, or one status marker if it is out of range.
// ----------------------------------------------------------------------------
module roman_numeral_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic        i_cfg_data,
    rne_num_if.sink     i_num,
    rne_chr_if.source   o_chr
);

    rne_pkg::t_cfg  r_cfg;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    rne_pkg::t_item f_item;
    rne_pkg::t_item q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prefix_mode <= 1'b1;
            r_cfg.lower_case  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rne_pkg::REG_PREFIX_MODE: r_cfg.prefix_mode <= i_cfg_data;
                default:                  r_cfg.lower_case  <= i_cfg_data;
            endcase
        end
    end

    rne_front u_front (
        .i_num    (i_num),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (f_item)
    );

    rne_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    rne_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_item    (q_item),
        .o_pop     (pop),
        .o_chr     (o_chr)
    );

endmodule

FILE: sv/rne_front.sv
// ----------------------------------------------------------------------------
// rne_front: input classification
// Accepts numbers while the queue has room and tags them with a status.
// ----------------------------------------------------------------------------
module rne_front (
    rne_num_if.sink         i_num,
    input  logic            i_q_full,
    output logic            o_push,
    output rne_pkg::t_item  o_item
);

    logic not_pos;
    logic too_large;

    assign i_num.ready = !i_q_full;
    assign o_push      = i_num.valid && !i_q_full;

    assign not_pos   = i_num.number_in[rne_pkg::NUM_W-1] || (i_num.number_in == '0);
    assign too_large = i_num.number_in > rne_pkg::NUM_W'(rne_pkg::MAX_VALUE);

    always_comb begin
        o_item.value = i_num.number_in[rne_pkg::VAL_W-1:0];
        if (not_pos) begin
            o_item.status = rne_pkg::ST_NOT_POS;
        end else if (too_large) begin
            o_item.status = rne_pkg::ST_TOO_LARGE;
        end else begin
            o_item.status = rne_pkg::ST_OK;
        end
    end

endmodule

FILE: sv/rne_queue.sv
// ----------------------------------------------------------------------------
// rne_queue: two-entry item queue
// Decouples classification from letter generation.
// ----------------------------------------------------------------------------
module rne_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rne_pkg::t_item  i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output rne_pkg::t_item  o_item
);

    rne_pkg::t_item r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: sv/rne_back.sv
// ----------------------------------------------------------------------------
// rne_back: letter sequencer
// Walks the place table one step per cycle while the output register is free, and drives the output register.
// ----------------------------------------------------------------------------
module rne_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rne_pkg::t_cfg   i_cfg,
    input  logic            i_q_empty,
    input  rne_pkg::t_item  i_item,
    output logic            o_pop,
    rne_chr_if.source       o_chr
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic               r_state, n_state;
    rne_pkg::t_val      r_val, n_val;
    rne_pkg::t_status   r_status, n_status;
    rne_pkg::t_place    r_place, n_place;
    logic               r_pend, n_pend;

    logic               r_ovalid, n_ovalid;
    rne_pkg::t_char     r_char, n_char;
    logic               r_last, n_last;
    rne_pkg::t_status   r_ostatus, n_ostatus;

    logic               slot_free;
    rne_pkg::t_val      add_v;
    rne_pkg::t_val      sub_v;
    rne_pkg::t_char     letter;
    logic               emit;

    assign slot_free = !r_ovalid || o_chr.ready;
    assign add_v     = rne_pkg::add_value(r_place);
    assign sub_v     = rne_pkg::sub_value(r_place);
    assign o_pop     = (r_state == S_IDLE) && !i_q_empty;

    assign o_chr.valid     = r_ovalid;
    assign o_chr.char_out  = r_char;
    assign o_chr.last_char = r_last;
    assign o_chr.status    = r_ostatus;

    always_comb begin
        n_state   = r_state;
        n_val     = r_val;
        n_status  = r_status;
        n_place   = r_place;
        n_pend    = r_pend;
        n_char    = r_char;
        n_last    = r_last;
        n_ostatus = r_ostatus;
        n_ovalid  = r_ovalid && !o_chr.ready;
        letter    = '0;
        emit      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state  = S_RUN;
                    n_val    = i_item.value;
                    n_status = i_item.status;
                    n_place  = '0;
                    n_pend   = 1'b0;
                end
            end
            S_RUN: begin
                if (r_status != rne_pkg::ST_OK) begin
                    if (slot_free) begin
                        emit      = 1'b1;
                        n_char    = '0;
                        n_last    = 1'b1;
                        n_ostatus = r_status;
                        n_state   = S_IDLE;
                    end
                end else if (r_pend) begin
                    // second letter of a subtractive pair is the place letter
                    if (slot_free) begin
                        emit    = 1'b1;
                        letter  = rne_pkg::add_letter(r_place);
                        n_last  = (r_val == '0);
                        n_pend  = 1'b0;
                        n_place = r_place + rne_pkg::t_place'(1);
                    end
                end else if (r_val >= add_v) begin
                    if (slot_free) begin
                        emit   = 1'b1;
                        letter = rne_pkg::add_letter(r_place);
                        n_val  = r_val - add_v;
                        n_last = (n_val == '0);
                    end
                end else if (i_cfg.prefix_mode && (sub_v != '0) && (r_val >= sub_v)) begin
                    if (slot_free) begin
                        emit   = 1'b1;
                        letter = rne_pkg::sub_first(r_place);
                        n_val  = r_val - sub_v;
                        n_last = 1'b0;
                        n_pend = 1'b1;
                    end
                end else begin
                    n_place = r_place + rne_pkg::t_place'(1);
                end

                if (emit && (r_status == rne_pkg::ST_OK)) begin
                    n_char    = i_cfg.lower_case ? (letter | rne_pkg::LOWER_BIT) : letter;
                    n_ostatus = rne_pkg::ST_OK;
                    if (n_last) begin
                        n_state = S_IDLE;
                    end
                end
                if (emit) begin
                    n_ovalid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val     <= n_val;
        r_status  <= n_status;
        r_place   <= n_place;
        r_char    <= n_char;
        r_last    <= n_last;
        r_ostatus <= n_ostatus;
    end

endmodule
